/* sv/assert_macros.svh */
// Assertion macros used by the top-level RTL file of the joystick pulse mapper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of aclk, off during reset.
`define JAP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Same-cycle implication.
`define JAP_ASSERT_IMPL(lbl, ante, cons, msg) \
    `JAP_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define JAP_ASSERT_NEXT(lbl, ante, cons, msg) \
    `JAP_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

/* sv/jap_pkg.sv */
// Package of the joystick pulse mapper: widths, codes, constants and shared types.
package jap_pkg;

    localparam int REG_W   = 22;
    localparam int VAL_W   = 16;
    localparam int POS_W   = 17;
    localparam int SPAN_W  = 23;
    localparam int PROD_W  = 40;
    localparam int EST_W   = 26;
    localparam int REM_W   = 17;
    localparam int WID_W   = 28;
    localparam int DUTY_W  = 23;
    localparam int ADDR_W  = 3;

    // register stages of one channel datapath
    localparam int NSTG    = 5;

    localparam int FULL_SCALE = 32767;

    // Bias that keeps the product non-negative; a multiple of the full scale.
    localparam logic [PROD_W:0] X_OFS = (41'd1 << 39) - (41'd1 << 24);
    localparam logic signed [WID_W-1:0] Q_BIAS = 28'sd16777216;
    localparam logic [DUTY_W-1:0] DUTY_MAX = 23'h7FFFFF;

    localparam logic [6:0] EVT_AXIS = 7'h02;
    localparam logic ACT_WAKE = 1'b1;
    localparam logic CH_STEER = 1'b0;
    localparam logic CH_DRIVE = 1'b1;

    localparam logic [REG_W-1:0] RST_STEER_MIN = 22'd1000000;
    localparam logic [REG_W-1:0] RST_STEER_MID = 22'd1500000;
    localparam logic [REG_W-1:0] RST_STEER_MAX = 22'd2000000;
    localparam logic [REG_W-1:0] RST_DRIVE_MIN = 22'd1100000;
    localparam logic [REG_W-1:0] RST_DRIVE_MID = 22'd1500000;
    localparam logic [REG_W-1:0] RST_DRIVE_MAX = 22'd1900000;

    typedef enum logic [ADDR_W-1:0] {
        REG_STEER_MIN = 3'd0,
        REG_STEER_MID = 3'd1,
        REG_STEER_MAX = 3'd2,
        REG_DRIVE_MIN = 3'd3,
        REG_DRIVE_MID = 3'd4,
        REG_DRIVE_MAX = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic                    steer_chg;
        logic                    drive_chg;
        logic signed [POS_W-1:0] steer_pos;
        logic signed [POS_W-1:0] drive_pos;
    } trk_t;

endpackage

/* sv/jap_track.sv */
// Axis event filter, channel positions and wake-to-wake change detection.
module jap_track (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        accept,
    input  logic                        action,
    input  logic [7:0]                  event_type,
    input  logic [7:0]                  event_number,
    input  logic signed [jap_pkg::VAL_W-1:0] event_value,
    output jap_pkg::trk_t               trk
);
    import jap_pkg::*;

    logic signed [VAL_W-1:0] steer_pos_reg, steer_pos_next;
    logic signed [POS_W-1:0] drive_pos_reg, drive_pos_next;
    logic                    steer_seen_reg, steer_seen_next;
    logic                    drive_seen_reg, drive_seen_next;
    logic signed [VAL_W-1:0] steer_snap_reg, steer_snap_next;
    logic signed [POS_W-1:0] drive_snap_reg, drive_snap_next;
    logic                    steer_snap_seen_reg, steer_snap_seen_next;
    logic                    drive_snap_seen_reg, drive_snap_seen_next;
    logic                    axis_hit;

    assign axis_hit = (event_type[6:0] == EVT_AXIS) && (event_number[7:1] == 7'd0);

    assign trk.steer_chg = (steer_seen_reg != steer_snap_seen_reg) ||
                           (steer_seen_reg && (steer_pos_reg != steer_snap_reg));
    assign trk.drive_chg = (drive_seen_reg != drive_snap_seen_reg) ||
                           (drive_seen_reg && (drive_pos_reg != drive_snap_reg));
    assign trk.steer_pos = POS_W'(steer_pos_reg);
    assign trk.drive_pos = drive_pos_reg;

    always_comb begin
        steer_pos_next       = steer_pos_reg;
        drive_pos_next       = drive_pos_reg;
        steer_seen_next      = steer_seen_reg;
        drive_seen_next      = drive_seen_reg;
        steer_snap_next      = steer_snap_reg;
        drive_snap_next      = drive_snap_reg;
        steer_snap_seen_next = steer_snap_seen_reg;
        drive_snap_seen_next = drive_snap_seen_reg;
        if (accept) begin
            if (action == ACT_WAKE) begin
                steer_snap_next      = steer_pos_reg;
                drive_snap_next      = drive_pos_reg;
                steer_snap_seen_next = steer_seen_reg;
                drive_snap_seen_next = drive_seen_reg;
            end else if (axis_hit) begin
                if (event_number[0]) begin
                    drive_pos_next  = -POS_W'(event_value);
                    drive_seen_next = 1'b1;
                end else begin
                    steer_pos_next  = event_value;
                    steer_seen_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steer_pos_reg       <= '0;
            drive_pos_reg       <= '0;
            steer_seen_reg      <= 1'b0;
            drive_seen_reg      <= 1'b0;
            steer_snap_reg      <= '0;
            drive_snap_reg      <= '0;
            steer_snap_seen_reg <= 1'b0;
            drive_snap_seen_reg <= 1'b0;
        end else begin
            steer_pos_reg       <= steer_pos_next;
            drive_pos_reg       <= drive_pos_next;
            steer_seen_reg      <= steer_seen_next;
            drive_seen_reg      <= drive_seen_next;
            steer_snap_reg      <= steer_snap_next;
            drive_snap_reg      <= drive_snap_next;
            steer_snap_seen_reg <= steer_snap_seen_next;
            drive_snap_seen_reg <= drive_snap_seen_next;
        end
    end

endmodule

/* sv/jap_lane.sv */
// One channel's pulse width datapath: span, multiply, floor divide by full scale, saturate.
module jap_lane (
    input  logic                             aclk,
    input  logic                             en,
    input  logic signed [jap_pkg::POS_W-1:0] pos,
    input  logic [jap_pkg::REG_W-1:0]        lo,
    input  logic [jap_pkg::REG_W-1:0]        mid,
    input  logic [jap_pkg::REG_W-1:0]        hi,
    output logic [jap_pkg::DUTY_W-1:0]       duty_ns
);
    import jap_pkg::*;

    logic signed [SPAN_W-1:0] span_a_reg, span_a_next;
    logic signed [POS_W-1:0]  v_a_reg;
    logic signed [PROD_W-1:0] prod_b_reg, prod_b_next;
    logic [PROD_W:0]          sum_c;
    logic [PROD_W-1:0]        x_c_reg, x_d_reg;
    logic [EST_W-1:0]         est_d_reg, est_d_next;
    logic [REM_W-1:0]         rem_e;
    logic [1:0]               corr_e;
    logic [EST_W-1:0]         q_e_reg, q_e_next;
    logic [REG_W-1:0]         mid_a_reg, mid_b_reg, mid_c_reg, mid_d_reg, mid_e_reg;
    logic signed [WID_W-1:0]  wid;

    always_comb begin
        if (pos > 0) begin
            span_a_next = $signed({1'b0, hi}) - $signed({1'b0, mid});
        end else begin
            span_a_next = $signed({1'b0, mid}) - $signed({1'b0, lo});
        end
    end

    assign prod_b_next = span_a_reg * v_a_reg;
    assign sum_c       = {prod_b_reg[PROD_W-1], prod_b_reg} + X_OFS;
    assign est_d_next  = {1'b0, x_c_reg[PROD_W-1:15]} + {16'd0, x_c_reg[PROD_W-1:30]};

    // remainder mod 2^17 is exact since it stays below three full scales
    assign rem_e = x_d_reg[REM_W-1:0] - {est_d_reg[1:0], 15'd0} + est_d_reg[REM_W-1:0];

    always_comb begin
        priority if (rem_e >= REM_W'(2 * FULL_SCALE)) begin
            corr_e = 2'd2;
        end else if (rem_e >= REM_W'(FULL_SCALE)) begin
            corr_e = 2'd1;
        end else begin
            corr_e = 2'd0;
        end
    end

    assign q_e_next = est_d_reg + {{(EST_W-2){1'b0}}, corr_e};

    assign wid = $signed({6'd0, mid_e_reg}) + $signed({2'd0, q_e_reg}) - Q_BIAS;

    always_comb begin
        priority if (wid < 0) begin
            duty_ns = '0;
        end else if (wid > $signed({5'd0, DUTY_MAX})) begin
            duty_ns = DUTY_MAX;
        end else begin
            duty_ns = wid[DUTY_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            span_a_reg <= span_a_next;
            v_a_reg    <= pos;
            mid_a_reg  <= mid;
            prod_b_reg <= prod_b_next;
            mid_b_reg  <= mid_a_reg;
            x_c_reg    <= sum_c[PROD_W-1:0];
            mid_c_reg  <= mid_b_reg;
            est_d_reg  <= est_d_next;
            x_d_reg    <= x_c_reg;
            mid_d_reg  <= mid_c_reg;
            q_e_reg    <= q_e_next;
            mid_e_reg  <= mid_d_reg;
        end
    end

endmodule

/* sv/joystick_axis_to_pwm_pulse.sv */
// Top level of the joystick axis to servo pulse width mapper.
// Takes one beat per cycle while the output register can drain. Joystick events
// update the steer and drive positions and give no result. A wake beat whose
// channels changed since the previous wake gives one or two result beats, steer
// first, through the lane stages and the output register; the last one carries
// m_last. The two channel datapaths (span, multiply, floor divide by 32767,
// saturate) are five register stages each and advance as one. A wake with both
// channels changed holds s_ready low while both of its beats wait in the
// two-entry output register, until the steer beat leaves. Configuration writes
// take effect at once and are meant only while idle.
module joystick_axis_to_pwm_pulse (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_action,
    input  logic [7:0]                        s_event_type,
    input  logic [7:0]                        s_event_number,
    input  logic signed [jap_pkg::VAL_W-1:0]  s_event_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_channel,
    output logic [jap_pkg::DUTY_W-1:0]        m_duty_ns,
    output logic                              m_last,
    input  logic                              cfg_we,
    input  logic [jap_pkg::ADDR_W-1:0]        cfg_addr,
    input  logic [jap_pkg::REG_W-1:0]         cfg_wdata
);
    import jap_pkg::*;

    logic [REG_W-1:0]  steer_min_reg, steer_mid_reg, steer_max_reg;
    logic [REG_W-1:0]  drive_min_reg, drive_mid_reg, drive_max_reg;
    logic [NSTG-1:0]   stg_st_reg, stg_st_next;
    logic [NSTG-1:0]   stg_dr_reg, stg_dr_next;
    logic              ob_st_reg, ob_st_next;
    logic              ob_dr_reg, ob_dr_next;
    logic [DUTY_W-1:0] ob_st_duty_reg, ob_dr_duty_reg;
    logic [DUTY_W-1:0] steer_duty, drive_duty;
    logic              en, accept, wake;
    trk_t              trk;

    assign en      = !(ob_st_reg || ob_dr_reg) || (m_ready && !(ob_st_reg && ob_dr_reg));
    assign s_ready = en;
    assign accept  = s_valid && en;
    assign wake    = accept && (s_action == ACT_WAKE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steer_min_reg <= RST_STEER_MIN;
            steer_mid_reg <= RST_STEER_MID;
            steer_max_reg <= RST_STEER_MAX;
            drive_min_reg <= RST_DRIVE_MIN;
            drive_mid_reg <= RST_DRIVE_MID;
            drive_max_reg <= RST_DRIVE_MAX;
        end else if (cfg_we) begin
            unique case (reg_idx_t'(cfg_addr))
                REG_STEER_MIN: steer_min_reg <= cfg_wdata;
                REG_STEER_MID: steer_mid_reg <= cfg_wdata;
                REG_STEER_MAX: steer_max_reg <= cfg_wdata;
                REG_DRIVE_MIN: drive_min_reg <= cfg_wdata;
                REG_DRIVE_MID: drive_mid_reg <= cfg_wdata;
                REG_DRIVE_MAX: drive_max_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    jap_track u_track (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .action       (s_action),
        .event_type   (s_event_type),
        .event_number (s_event_number),
        .event_value  (s_event_value),
        .trk          (trk)
    );

    jap_lane u_steer (
        .aclk    (aclk),
        .en      (en),
        .pos     (trk.steer_pos),
        .lo      (steer_min_reg),
        .mid     (steer_mid_reg),
        .hi      (steer_max_reg),
        .duty_ns (steer_duty)
    );

    jap_lane u_drive (
        .aclk    (aclk),
        .en      (en),
        .pos     (trk.drive_pos),
        .lo      (drive_min_reg),
        .mid     (drive_mid_reg),
        .hi      (drive_max_reg),
        .duty_ns (drive_duty)
    );

    always_comb begin
        stg_st_next = stg_st_reg;
        stg_dr_next = stg_dr_reg;
        ob_st_next  = ob_st_reg;
        ob_dr_next  = ob_dr_reg;
        if (en) begin
            stg_st_next = {stg_st_reg[NSTG-2:0], wake && trk.steer_chg};
            stg_dr_next = {stg_dr_reg[NSTG-2:0], wake && trk.drive_chg};
            ob_st_next  = stg_st_reg[NSTG-1];
            ob_dr_next  = stg_dr_reg[NSTG-1];
        end else if (m_ready) begin
            // both pending: steer beat leaves first
            ob_st_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_st_reg <= '0;
            stg_dr_reg <= '0;
            ob_st_reg  <= 1'b0;
            ob_dr_reg  <= 1'b0;
        end else begin
            stg_st_reg <= stg_st_next;
            stg_dr_reg <= stg_dr_next;
            ob_st_reg  <= ob_st_next;
            ob_dr_reg  <= ob_dr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ob_st_duty_reg <= steer_duty;
            ob_dr_duty_reg <= drive_duty;
        end
    end

    assign m_valid   = ob_st_reg || ob_dr_reg;
    assign m_channel = ob_st_reg ? CH_STEER : CH_DRIVE;
    assign m_duty_ns = ob_st_reg ? ob_st_duty_reg : ob_dr_duty_reg;
    assign m_last    = !(ob_st_reg && ob_dr_reg);

`include "assert_macros.svh"

    `JAP_ASSERT_IMPL(a_first_is_steer, m_valid && !m_last, m_channel == CH_STEER, "non-last beat not steer")
    `JAP_ASSERT_IMPL(a_stall_needs_out, !s_ready, m_valid, "input stalled with empty output")
    `JAP_ASSERT_NEXT(a_drive_follows, ob_st_reg && ob_dr_reg && m_ready, m_valid && m_last && (m_channel == CH_DRIVE), "drive beat lost after steer")
    `JAP_ASSERT_IMPL(a_last_frees_input, m_valid && m_ready && m_last, s_ready, "input held after last beat")

endmodule

/* test/tb_joystick_axis_to_pwm_pulse.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the joystick axis to servo pulse width mapper.
module tb_joystick_axis_to_pwm_pulse;
    import jap_pkg::*;

    localparam int PIPE_DEPTH = 6;
    localparam int RANDOM_ITEMS = 1600;
    localparam longint FULL_DEFLECT = 32767;
    localparam logic ACT_EVENT = ~ACT_WAKE;
    localparam logic [7:0] TYPE_AXIS = {1'b0, EVT_AXIS};
    localparam logic [7:0] TYPE_AXIS_INIT = {1'b1, EVT_AXIS};
    localparam logic [7:0] AXIS_STEER = {7'd0, CH_STEER};
    localparam logic [7:0] AXIS_DRIVE = {7'd0, CH_DRIVE};
    localparam logic [ADDR_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [ADDR_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct {
        logic              channel;
        logic [DUTY_W-1:0] duty_ns;
        logic              last;
    } pulse_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic                     s_action;
    logic [7:0]               s_event_type;
    logic [7:0]               s_event_number;
    logic signed [VAL_W-1:0]  s_event_value;
    logic                     m_valid;
    logic                     m_ready;
    logic                     m_channel;
    logic [DUTY_W-1:0]        m_duty_ns;
    logic                     m_last;
    logic                     cfg_we;
    logic [ADDR_W-1:0]        cfg_addr;
    logic [REG_W-1:0]         cfg_wdata;

    // mapper state as the block should hold it
    logic [REG_W-1:0]         width_regs [0:5];
    logic signed [VAL_W-1:0]  steer_pos, steer_snap;
    logic signed [POS_W-1:0]  drive_pos, drive_snap;
    logic                     steer_seen, drive_seen, steer_snap_seen, drive_snap_seen;

    pulse_t pulse_q [$];
    pulse_t head;
    int     fail_count = 0;
    int     src_idle_pct = 0;
    int     snk_idle_pct = 0;

    joystick_axis_to_pwm_pulse dut (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial begin
        #5ms;
        $display("[joystick_axis_to_pwm_pulse] ERROR");
        $finish;
    end

    function automatic logic [DUTY_W-1:0] scaled_width(input logic [REG_W-1:0] lo,
                                                        input logic [REG_W-1:0] hi,
                                                        input logic [REG_W-1:0] mid,
                                                        input longint pos);
        longint span, prod, quot, width;
        if (pos == 0)
            return {1'b0, mid};
        span = (pos > 0) ? longint'(hi) - longint'(mid) : longint'(mid) - longint'(lo);
        prod = span * pos;
        quot = prod / FULL_DEFLECT;
        if (prod % FULL_DEFLECT != 0 && prod < 0)
            quot = quot - 1;
        width = longint'(mid) + quot;
        if (width < 0)
            width = 0;
        if (width > longint'(DUTY_MAX))
            width = longint'(DUTY_MAX);
        return width[DUTY_W-1:0];
    endfunction

    task automatic predict_pulses(input logic action, input logic [7:0] etype,
                                  input logic [7:0] enumber,
                                  input logic signed [VAL_W-1:0] evalue);
        logic steer_chg, drive_chg;
        if (action != ACT_WAKE) begin
            if (etype[6:0] == EVT_AXIS && enumber[7:1] == 7'd0) begin
                if (enumber[0] == CH_DRIVE) begin
                    drive_pos = -{evalue[VAL_W-1], evalue};
                    drive_seen = 1'b1;
                end else begin
                    steer_pos = evalue;
                    steer_seen = 1'b1;
                end
            end
        end else begin
            steer_chg = (steer_seen != steer_snap_seen) ||
                        (steer_seen && steer_pos != steer_snap);
            drive_chg = (drive_seen != drive_snap_seen) ||
                        (drive_seen && drive_pos != drive_snap);
            if (steer_chg)
                pulse_q.push_back('{CH_STEER,
                    scaled_width(width_regs[REG_STEER_MIN], width_regs[REG_STEER_MAX],
                                 width_regs[REG_STEER_MID], steer_pos), !drive_chg});
            if (drive_chg)
                pulse_q.push_back('{CH_DRIVE,
                    scaled_width(width_regs[REG_DRIVE_MIN], width_regs[REG_DRIVE_MAX],
                                 width_regs[REG_DRIVE_MID], drive_pos), 1'b1});
            steer_snap = steer_pos;
            drive_snap = drive_pos;
            steer_snap_seen = steer_seen;
            drive_snap_seen = drive_seen;
        end
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_item(input logic action, input logic [7:0] etype,
                             input logic [7:0] enumber,
                             input logic signed [VAL_W-1:0] evalue);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= action;
        s_event_type <= etype;
        s_event_number <= enumber;
        s_event_value <= evalue;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predict_pulses(action, etype, enumber, evalue);
        @(negedge aclk);
    endtask

    task automatic send_axis(input logic [7:0] axis, input logic signed [VAL_W-1:0] pos);
        send_item(ACT_EVENT, TYPE_AXIS, axis, pos);
    endtask

    task automatic send_wake();
        send_item(ACT_WAKE, 8'($urandom), 8'($urandom), 16'($urandom));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pulse_q.size() != 0)
            @(negedge aclk);
    endtask

    task automatic settle();
        wait_drained();
        repeat (PIPE_DEPTH + 4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [REG_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        if (addr <= REG_DRIVE_MAX)
            width_regs[addr] = data;
        @(negedge aclk);
    endtask

    task automatic apply_settings(input logic [REG_W-1:0] s_min, input logic [REG_W-1:0] s_mid,
                                  input logic [REG_W-1:0] s_max, input logic [REG_W-1:0] d_min,
                                  input logic [REG_W-1:0] d_mid, input logic [REG_W-1:0] d_max);
        write_reg(REG_STEER_MIN, s_min);
        write_reg(REG_STEER_MID, s_mid);
        write_reg(REG_STEER_MAX, s_max);
        write_reg(REG_DRIVE_MIN, d_min);
        write_reg(REG_DRIVE_MID, d_mid);
        write_reg(REG_DRIVE_MAX, d_max);
        // unmapped indexes must leave the table alone
        write_reg(REG_SPARE_6, REG_W'($urandom));
        write_reg(REG_SPARE_7, REG_W'($urandom));
        cfg_we <= 1'b0;
    endtask

    function automatic logic [REG_W-1:0] pick_setting();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return REG_W'($urandom_range(4000000));
            default: return REG_W'($urandom_range(2100000, 900000));
        endcase
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_position();
        case ($urandom_range(7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return '0;
            3: return VAL_W'($urandom_range(2)) - 16'sd1;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // result beats are checked against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pulse_q.size() == 0) begin
                $display("%0t: unexpected beat: expected none, actual ch %0d duty %0d last %0d",
                         $time, m_channel, m_duty_ns, m_last);
                fail_count++;
            end else begin
                head = pulse_q.pop_front();
                if (m_channel !== head.channel) begin
                    $display("%0t: channel: expected %0d actual %0d",
                             $time, head.channel, m_channel);
                    fail_count++;
                end
                if (m_duty_ns !== head.duty_ns) begin
                    $display("%0t: duty_ns (ch %0d): expected %0d actual %0d",
                             $time, head.channel, head.duty_ns, m_duty_ns);
                    fail_count++;
                end
                if (m_last !== head.last) begin
                    $display("%0t: last (ch %0d): expected %0d actual %0d",
                             $time, head.channel, head.last, m_last);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_reset_widths();
        send_wake();
        send_axis(AXIS_STEER, 16'sh7FFF);
        send_wake();
        send_axis(AXIS_DRIVE, 16'sh8000);
        send_wake();
        send_axis(AXIS_STEER, 16'sh8000);
        send_axis(AXIS_DRIVE, 16'sh7FFF);
        send_wake();
        send_wake();
        send_axis(AXIS_STEER, '0);
        send_wake();
    endtask

    task automatic test_event_filter();
        send_item(ACT_EVENT, TYPE_AXIS_INIT, AXIS_DRIVE, 16'sd1234);
        send_item(ACT_EVENT, TYPE_AXIS, 8'd2, 16'sd500);
        send_item(ACT_EVENT, TYPE_AXIS, 8'hFF, -16'sd500);
        send_item(ACT_EVENT, 8'h03, AXIS_STEER, 16'sd77);
        send_item(ACT_EVENT, 8'hFF, AXIS_STEER, 16'sd77);
        send_item(ACT_EVENT, 8'h00, AXIS_DRIVE, 16'sd77);
        send_wake();
    endtask

    task automatic test_inverted_ranges();
        settle();
        apply_settings(22'd1800000, 22'd1500000, 22'd1200000, '0, '1, '0);
        send_axis(AXIS_STEER, 16'sh7FFF);
        send_axis(AXIS_DRIVE, 16'sh8000);
        send_wake();
        send_axis(AXIS_STEER, 16'sh8000);
        send_axis(AXIS_DRIVE, 16'sh7FFF);
        send_wake();
        settle();
        apply_settings('0, '0, '0, '0, '0, '1);
        send_axis(AXIS_STEER, -16'sd1);
        send_axis(AXIS_DRIVE, -16'sd1);
        send_wake();
    endtask

    task automatic test_random_traffic(input int src_pct, input int snk_pct, input int n_items);
        int sent;
        int pick;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        for (int phase = 0; phase < 2; phase++) begin
            settle();
            apply_settings(pick_setting(), pick_setting(), pick_setting(),
                           pick_setting(), pick_setting(), pick_setting());
            sent = 0;
            while (sent < n_items / 2) begin
                pick = $urandom_range(99);
                if (pick < 3)
                    wait_drained();
                if (pick < 30) begin
                    send_wake();
                    sent++;
                end else if (pick < 85) begin
                    send_item(ACT_EVENT, $urandom_range(1) ? TYPE_AXIS_INIT : TYPE_AXIS,
                              $urandom_range(1) ? AXIS_DRIVE : AXIS_STEER, pick_position());
                    sent++;
                end else begin
                    send_item(ACT_EVENT, 8'($urandom), 8'($urandom), 16'($urandom));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_action = 1'b0;
        s_event_type = '0;
        s_event_number = '0;
        s_event_value = '0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        width_regs[REG_STEER_MIN] = RST_STEER_MIN;
        width_regs[REG_STEER_MID] = RST_STEER_MID;
        width_regs[REG_STEER_MAX] = RST_STEER_MAX;
        width_regs[REG_DRIVE_MIN] = RST_DRIVE_MIN;
        width_regs[REG_DRIVE_MID] = RST_DRIVE_MID;
        width_regs[REG_DRIVE_MAX] = RST_DRIVE_MAX;
        steer_pos = '0;
        drive_pos = '0;
        steer_snap = '0;
        drive_snap = '0;
        steer_seen = 1'b0;
        drive_seen = 1'b0;
        steer_snap_seen = 1'b0;
        drive_snap_seen = 1'b0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_widths();
        test_event_filter();
        test_inverted_ranges();
        test_random_traffic(28, 55, RANDOM_ITEMS / 3);
        test_random_traffic(55, 28, RANDOM_ITEMS / 3);
        test_random_traffic(0, 0, RANDOM_ITEMS / 3);

        settle();
        repeat (20) @(negedge aclk);
        if (pulse_q.size() != 0) begin
            $display("%0t: %0d pulse beats never arrived, expected ch %0d duty %0d", $time,
                     pulse_q.size(), pulse_q[0].channel, pulse_q[0].duty_ns);
            fail_count++;
        end
        if (fail_count == 0)
            $display("[joystick_axis_to_pwm_pulse] OK");
        else
            $display("[joystick_axis_to_pwm_pulse] ERROR");
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/jap_pkg.sv
sv/jap_track.sv
sv/jap_lane.sv
sv/joystick_axis_to_pwm_pulse.sv
test/tb_joystick_axis_to_pwm_pulse.sv
